// ===== rtl/nv21wm_pkg.sv =====
// Shared types, codes and helper functions for the NV21 watermark overlay core.
// No dependencies; imported by nv21wm_blend and nv21_watermark_overlay_core.
`default_nettype none

package nv21wm_pkg;

    localparam int COORD_BITS  = 13;
    localparam int DIM_BITS    = 14;
    localparam int MARGIN_BITS = 11;

    localparam logic [7:0] LUMA_THRESHOLD = 8'd16;
    localparam logic [7:0] UV_NEUTRAL     = 8'h80;
    localparam logic [7:0] FULL_SCALE     = 8'd255;
    localparam logic [9:0] DPI_UNIT       = 10'd160;

    localparam logic [2:0] POS_TL  = 3'd0;
    localparam logic [2:0] POS_BL  = 3'd1;
    localparam logic [2:0] POS_BR  = 3'd2;
    localparam logic [2:0] POS_TR  = 3'd3;
    localparam logic [2:0] POS_MID = 3'd4;

    localparam logic [1:0] MODE_COVER = 2'd0;
    localparam logic [1:0] MODE_TRANS = 2'd1;
    localparam logic [1:0] MODE_WHITE = 2'd2;
    localparam logic [1:0] MODE_OFF   = 2'd3;

    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_MARK_WIDTH   = 3'd2;
    localparam logic [2:0] REG_MARK_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_MARGIN_DP    = 3'd4;
    localparam logic [2:0] REG_SCREEN_DPI   = 3'd5;
    localparam logic [2:0] REG_PLACEMENT    = 3'd6;
    localparam logic [2:0] REG_BLEND_MODE   = 3'd7;

    typedef logic signed [15:0] coord_t;

    function automatic logic [2:0] mirror_pos(input logic [2:0] pos);
        if (pos == POS_MID)
            return POS_MID;
        return {1'b0, ~pos[1:0]};
    endfunction

    function automatic logic [2:0] rotate_pos(input logic [2:0] pos, input logic [1:0] rot);
        logic [1:0] sum;
        sum = pos[1:0] + rot;
        if (pos == POS_MID)
            return POS_MID;
        return {1'b0, sum};
    endfunction

    // floor(dpi / 160) for a 10-bit dpi
    function automatic logic [2:0] dpi_scale(input logic [9:0] dpi);
        if (dpi >= 10'(6 * DPI_UNIT))
            return 3'd6;
        else if (dpi >= 10'(5 * DPI_UNIT))
            return 3'd5;
        else if (dpi >= 10'(4 * DPI_UNIT))
            return 3'd4;
        else if (dpi >= 10'(3 * DPI_UNIT))
            return 3'd3;
        else if (dpi >= 10'(2 * DPI_UNIT))
            return 3'd2;
        else if (dpi >= DPI_UNIT)
            return 3'd1;
        return 3'd0;
    endfunction

    // floor(p / 255), exact for any product of two bytes
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/nv21wm_blend.sv =====
// Two-stage luma blend: floor(w*w/255) + floor((255-w)*f/255).
// Depends on nv21wm_pkg for div255 and FULL_SCALE.
`default_nettype none

module nv21wm_blend
    import nv21wm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic [7:0] mark_luma,
    input  wire logic [7:0] frame_luma,
    output logic      [7:0] blend_luma
);

    logic [15:0] mark_sq_reg;
    logic [15:0] frame_part_reg;
    logic [7:0]  blend_reg;
    logic [7:0]  inv_luma;
    logic [7:0]  blend_next;

    assign inv_luma   = FULL_SCALE - mark_luma;
    assign blend_next = div255(mark_sq_reg) + div255(frame_part_reg);

    always_ff @(posedge clk)
    begin
        mark_sq_reg    <= {8'd0, mark_luma} * {8'd0, mark_luma};
        frame_part_reg <= {8'd0, inv_luma} * {8'd0, frame_luma};
        blend_reg      <= blend_next;
    end

    assign blend_luma = blend_reg;

endmodule

`default_nettype wire

// ===== rtl/nv21_watermark_overlay_core.sv =====
// Top level of the NV21 watermark overlay: config registers and a four-stage pixel pipeline.
// Depends on nv21wm_pkg and nv21wm_blend.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  pixel in | start, busy             | mark_col, mark_row, mark_luma, mark_chroma,
//           |                         | frame_luma
//  config   | cfg_valid, cfg_ready    | cfg_index, cfg_data
//  write out| done                    | dest_col, dest_row, luma_write, new_luma,
//           |                         | chroma_write, chroma_row, new_chroma
//
// One pixel per cycle while busy is low; every transaction yields one result, strobed by done.
// Stages: anchor map and margin, raw start point plus blend products,
// pull-back and clamp plus divide, destination add and frame compare.
// busy is high only in the first cycle after reset; cfg_ready is always high.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module nv21_watermark_overlay_core
    import nv21wm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [COORD_BITS-1:0] mark_col,
    input  wire logic [COORD_BITS-1:0] mark_row,
    input  wire logic [7:0]            mark_luma,
    input  wire logic [7:0]            mark_chroma,
    input  wire logic [7:0]            frame_luma,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [DIM_BITS-1:0]   cfg_data,
    output logic                       done,
    output logic [DIM_BITS-1:0]        dest_col,
    output logic [DIM_BITS-1:0]        dest_row,
    output logic                       luma_write,
    output logic [7:0]                 new_luma,
    output logic                       chroma_write,
    output logic [DIM_BITS-2:0]        chroma_row,
    output logic [7:0]                 new_chroma
);

    logic [DIM_BITS-1:0] frame_width_reg;
    logic [DIM_BITS-1:0] frame_height_reg;
    logic [DIM_BITS-1:0] mark_width_reg;
    logic [DIM_BITS-1:0] mark_height_reg;
    logic [7:0]          margin_dp_reg;
    logic [9:0]          screen_dpi_reg;
    logic [5:0]          placement_reg;
    logic [2:0]          blend_mode_reg;
    logic                busy_reg;

    logic accept;

    // stage A
    logic                   a_valid_reg;
    logic                   a_ok_reg;
    logic [2:0]             a_pos_reg;
    logic [MARGIN_BITS-1:0] a_margin_reg;
    logic [COORD_BITS-1:0]  a_col_reg;
    logic [COORD_BITS-1:0]  a_row_reg;
    logic [7:0]             a_wl_reg;
    logic [7:0]             a_wc_reg;
    logic [7:0]             a_fl_reg;
    logic                   a_ok_next;
    logic [2:0]             a_pos_next;
    logic [2:0]             pos_mirrored;
    logic [MARGIN_BITS-1:0] a_margin_next;

    // stage B
    logic                  b_valid_reg;
    logic                  b_ok_reg;
    coord_t                b_x_reg;
    coord_t                b_y_reg;
    logic [COORD_BITS-1:0] b_col_reg;
    logic [COORD_BITS-1:0] b_row_reg;
    logic [7:0]            b_wl_reg;
    logic [7:0]            b_wc_reg;
    coord_t                b_x_next;
    coord_t                b_y_next;

    // stage C
    logic                  c_valid_reg;
    logic                  c_ok_reg;
    logic [DIM_BITS-1:0]   c_sx_reg;
    logic [DIM_BITS-1:0]   c_sy_reg;
    logic [COORD_BITS-1:0] c_col_reg;
    logic [COORD_BITS-1:0] c_row_reg;
    logic [7:0]            c_wl_reg;
    logic [7:0]            c_wc_reg;
    coord_t                x_fit;
    coord_t                y_fit;
    logic [DIM_BITS-1:0]   c_sx_next;
    logic [DIM_BITS-1:0]   c_sy_next;
    logic [7:0]            blend_luma;

    // output stage
    logic                done_reg;
    logic [DIM_BITS-1:0] dest_col_reg;
    logic [DIM_BITS-1:0] dest_row_reg;
    logic                luma_write_reg;
    logic [7:0]          new_luma_reg;
    logic                chroma_write_reg;
    logic [DIM_BITS-2:0] chroma_row_reg;
    logic [7:0]          new_chroma_reg;
    logic [DIM_BITS:0]   dx;
    logic [DIM_BITS:0]   dy;
    logic                write_next;
    logic [7:0]          luma_next;
    logic                chroma_next;
    logic [7:0]          cval_next;

    coord_t fw;
    coord_t fh;
    coord_t mw;
    coord_t mh;
    coord_t mg;

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_BITS'(1920);
            frame_height_reg <= DIM_BITS'(1080);
            mark_width_reg   <= DIM_BITS'(64);
            mark_height_reg  <= DIM_BITS'(64);
            margin_dp_reg    <= 8'd0;
            screen_dpi_reg   <= DPI_UNIT;
            placement_reg    <= {3'd0, POS_TR};
            blend_mode_reg   <= {1'b0, MODE_COVER};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_MARK_WIDTH:   mark_width_reg   <= cfg_data;
                REG_MARK_HEIGHT:  mark_height_reg  <= cfg_data;
                REG_MARGIN_DP:    margin_dp_reg    <= cfg_data[7:0];
                REG_SCREEN_DPI:   screen_dpi_reg   <= cfg_data[9:0];
                REG_PLACEMENT:    placement_reg    <= cfg_data[5:0];
                REG_BLEND_MODE:   blend_mode_reg   <= cfg_data[2:0];
                default:          ;
            endcase
        end
    end

    // stage A: map the anchor, form the margin, reject dead pixels
    always_comb
    begin
        a_ok_next = (placement_reg[2:0] <= POS_MID)
                 && (blend_mode_reg[1:0] != MODE_OFF)
                 && ({1'b0, mark_col} < mark_width_reg)
                 && ({1'b0, mark_row} < mark_height_reg);
        pos_mirrored  = placement_reg[5] ? mirror_pos(placement_reg[2:0]) : placement_reg[2:0];
        a_pos_next    = rotate_pos(pos_mirrored, placement_reg[4:3]);
        a_margin_next = {8'd0, dpi_scale(screen_dpi_reg)} * {3'd0, margin_dp_reg};
    end

    // stage B: raw start point
    assign fw = {2'b00, frame_width_reg};
    assign fh = {2'b00, frame_height_reg};
    assign mw = {2'b00, mark_width_reg};
    assign mh = {2'b00, mark_height_reg};
    assign mg = {5'd0, a_margin_reg};

    always_comb
    begin
        case (a_pos_reg)
            POS_MID:
            begin
                b_x_next = (fw >>> 1) - (mw >>> 1);
                b_y_next = (fh >>> 1) - (mh >>> 1);
            end
            POS_TL:
            begin
                b_x_next = mg;
                b_y_next = mg;
            end
            POS_TR:
            begin
                b_x_next = fw - mw - mg;
                b_y_next = mg;
            end
            POS_BL:
            begin
                b_x_next = mg;
                b_y_next = fh - mh - mg;
            end
            default:
            begin
                b_x_next = fw - mw - mg;
                b_y_next = fh - mh - mg;
            end
        endcase
    end

    nv21wm_blend u_blend (
        .clk        (clk),
        .mark_luma  (a_wl_reg),
        .frame_luma (a_fl_reg),
        .blend_luma (blend_luma)
    );

    // stage C: pull back inside the frame, clamp at zero
    always_comb
    begin
        x_fit     = (b_x_reg + mw > fw) ? fw - mw : b_x_reg;
        y_fit     = (b_y_reg + mh > fh) ? fh - mh : b_y_reg;
        c_sx_next = (x_fit > 16'sd0) ? x_fit[DIM_BITS-1:0] : '0;
        c_sy_next = (y_fit > 16'sd0) ? y_fit[DIM_BITS-1:0] : '0;
    end

    // output stage: destination and write decision
    always_comb
    begin
        dx = {2'b00, c_col_reg} + {1'b0, c_sx_reg};
        dy = {2'b00, c_row_reg} + {1'b0, c_sy_reg};
        write_next = c_ok_reg
                  && (dx < {1'b0, frame_width_reg})
                  && (dy < {1'b0, frame_height_reg})
                  && (c_wl_reg > LUMA_THRESHOLD);
        case (blend_mode_reg[1:0])
            MODE_COVER:
            begin
                luma_next   = c_wl_reg;
                chroma_next = !c_row_reg[0] && !blend_mode_reg[2];
                cval_next   = c_wc_reg;
            end
            MODE_WHITE:
            begin
                luma_next   = blend_luma;
                chroma_next = !c_row_reg[0] && !blend_mode_reg[2];
                cval_next   = UV_NEUTRAL;
            end
            default:
            begin
                luma_next   = blend_luma;
                chroma_next = 1'b0;
                cval_next   = UV_NEUTRAL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            busy_reg    <= 1'b0;
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            done_reg    <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ok_reg     <= a_ok_next;
        a_pos_reg    <= a_pos_next;
        a_margin_reg <= a_margin_next;
        a_col_reg    <= mark_col;
        a_row_reg    <= mark_row;
        a_wl_reg     <= mark_luma;
        a_wc_reg     <= mark_chroma;
        a_fl_reg     <= frame_luma;

        b_ok_reg  <= a_ok_reg;
        b_x_reg   <= b_x_next;
        b_y_reg   <= b_y_next;
        b_col_reg <= a_col_reg;
        b_row_reg <= a_row_reg;
        b_wl_reg  <= a_wl_reg;
        b_wc_reg  <= a_wc_reg;

        c_ok_reg  <= b_ok_reg;
        c_sx_reg  <= c_sx_next;
        c_sy_reg  <= c_sy_next;
        c_col_reg <= b_col_reg;
        c_row_reg <= b_row_reg;
        c_wl_reg  <= b_wl_reg;
        c_wc_reg  <= b_wc_reg;

        if (write_next)
        begin
            dest_col_reg     <= dx[DIM_BITS-1:0];
            dest_row_reg     <= dy[DIM_BITS-1:0];
            luma_write_reg   <= 1'b1;
            new_luma_reg     <= luma_next;
            chroma_write_reg <= chroma_next;
            chroma_row_reg   <= chroma_next ? dy[DIM_BITS-1:1] : '0;
            new_chroma_reg   <= chroma_next ? cval_next : 8'd0;
        end
        else
        begin
            dest_col_reg     <= '0;
            dest_row_reg     <= '0;
            luma_write_reg   <= 1'b0;
            new_luma_reg     <= 8'd0;
            chroma_write_reg <= 1'b0;
            chroma_row_reg   <= '0;
            new_chroma_reg   <= 8'd0;
        end
    end

    assign done         = done_reg;
    assign dest_col     = dest_col_reg;
    assign dest_row     = dest_row_reg;
    assign luma_write   = luma_write_reg;
    assign new_luma     = new_luma_reg;
    assign chroma_write = chroma_write_reg;
    assign chroma_row   = chroma_row_reg;
    assign new_chroma   = new_chroma_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##4 done)
        else $error("result strobe missing four cycles after transaction");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !luma_write |-> dest_col == '0 && dest_row == '0 && new_luma == 8'd0
                                && !chroma_write && chroma_row == '0 && new_chroma == 8'd0)
        else $error("fields not cleared on a dropped pixel");

    a_chroma_needs_luma: assert property (@(posedge clk) disable iff (!rst_n)
        done && chroma_write |-> luma_write && chroma_row == dest_row[DIM_BITS-1:1])
        else $error("chroma write inconsistent with luma destination");

    a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(c_valid_reg))
        else $error("result strobe without a pipeline transaction");

endmodule

`default_nettype wire
